// ===== rtl/cvq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cvq_pkg;

    // Stream payload widths (whole bytes)
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    // Field widths
    localparam int SAMPLE_W  = 15;
    localparam int PITCH_W   = 18;
    localparam int STEP_W    = 6;
    localparam int CHAN_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int TBL_DEPTH = 16;
    localparam int TBL_AW    = 4;

    // Pitch constants, 1 LSB = 1/1200 V
    localparam int ONE_VOLT = 1200;
    localparam int SEMITONE = 100;
    localparam logic signed [SAMPLE_W-1:0] GATE_ON_LEVEL = 15'sd1200;
    localparam logic [4:0] CHROMATIC_SIZE = 5'd12;
    localparam logic [4:0] SCALE_MAX      = 5'd16;

    // Config register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_SPAN_LOW   = 3'd0;
    localparam cfg_index_t CFG_SPAN_HIGH  = 3'd1;
    localparam cfg_index_t CFG_NOTE_RANGE = 3'd2;
    localparam cfg_index_t CFG_SCALE_SIZE = 3'd3;
    localparam cfg_index_t CFG_GATE_USED  = 3'd4;

    // Result beat kinds
    typedef logic [1:0] emit_kind_t;
    localparam emit_kind_t EMIT_OFF   = 2'd0;  // gate closed, single beat
    localparam emit_kind_t EMIT_CLOSE = 2'd1;  // close old channel, advance
    localparam emit_kind_t EMIT_PLAY  = 2'd2;  // play quantized pitch

    typedef struct packed {
        logic       cap;         // capture sample on accept
        logic       tbl_wr;      // scale table write on accept
        logic       prep;        // span difference and product
        logic       div_start;   // kick shared divider
        logic       div_sel;     // 0: step scaling, 1: degree/octave split
        logic       s_latch;     // latch step
        logic       dm_latch;    // latch degree and octave
        logic       pitch_calc;  // form pitch
        logic       emit_en;     // load output register
        emit_kind_t emit_kind;
    } cmd_t;

    typedef struct packed {
        logic playing;
        logic div_done;
        logic new_note;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/cvq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cvq_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/cvq_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
// Quotient must fit in QW bits; callers guarantee it or discard the result.
module cvq_div #(
    parameter int NW  = 23,
    parameter int DVW = 16,
    parameter int QW  = 6
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [NW-1:0]  dividend,
    input  wire logic [DVW-1:0] divisor,
    output logic                done,
    output logic      [QW-1:0]  quotient,
    output logic      [NW-1:0]  remainder
);

    localparam int CW   = (NW > DVW + QW) ? NW : DVW + QW;
    localparam int CNTW = (QW > 1) ? $clog2(QW) : 1;

    logic [CW-1:0]   n_reg;
    logic [DVW-1:0]  d_reg;
    logic [QW-1:0]   q_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [CW-1:0] shifted;
    logic          fits;

    assign shifted = CW'(d_reg) << cnt_reg;
    assign fits    = (n_reg >= shifted);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == '0)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= CW'(dividend);
            d_reg   <= divisor;
            q_reg   <= '0;
            cnt_reg <= CNTW'(QW - 1);
        end else if (busy_reg) begin
            if (fits) begin
                n_reg          <= n_reg - shifted;
                q_reg[cnt_reg] <= 1'b1;
            end
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = n_reg[NW-1:0];

endmodule

`default_nettype wire

// ===== rtl/cvq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cvq_dp #(
    parameter int VOICES    = 16,
    parameter int MAX_STEPS = 48
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // config
    input  wire logic                            cfg_valid,
    input  wire logic [cvq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cvq_pkg::SAMPLE_W-1:0]    cfg_data,
    // input beat payload
    input  wire logic [cvq_pkg::S_TDATA_W-1:0]   s_tdata,
    // control
    input  wire cvq_pkg::cmd_t                   cmd,
    output cvq_pkg::sts_t                        sts,
    // result channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [cvq_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                                 m_tlast
);

    import cvq_pkg::*;

    localparam int QW  = $clog2(MAX_STEPS);
    localparam int NW  = SAMPLE_W + QW + 2;
    localparam int DVW = SAMPLE_W + 1;

    // ---------------- config registers ----------------
    logic signed [SAMPLE_W-1:0] span_low_reg;
    logic signed [SAMPLE_W-1:0] span_high_reg;
    logic [5:0]                 note_range_reg;
    logic [4:0]                 scale_size_reg;
    logic                       gate_used_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_low_reg   <= '0;
            span_high_reg  <= 15'sd12000;
            note_range_reg <= 6'd16;
            scale_size_reg <= 5'd0;
            gate_used_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SPAN_LOW:   span_low_reg   <= cfg_data;
                CFG_SPAN_HIGH:  span_high_reg  <= cfg_data;
                CFG_NOTE_RANGE: note_range_reg <= cfg_data[5:0];
                CFG_SCALE_SIZE: scale_size_reg <= cfg_data[4:0];
                CFG_GATE_USED:  gate_used_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- input fields ----------------
    logic signed [SAMPLE_W-1:0] in_pitch;
    logic signed [SAMPLE_W-1:0] in_gate;
    logic [TBL_AW-1:0]          in_idx;
    logic [SAMPLE_W-1:0]        in_val;

    assign in_pitch = s_tdata[14:0];
    assign in_gate  = s_tdata[29:15];
    assign in_idx   = s_tdata[33:30];
    assign in_val   = s_tdata[48:34];

    assign sts.playing = !gate_used_reg || (in_gate >= GATE_ON_LEVEL);

    // ---------------- effective config ----------------
    logic [6:0]    nr_eff;
    logic [QW-1:0] top;
    logic [4:0]    ss_clamp;
    logic          chrom;
    logic [4:0]    ss_eff;

    assign nr_eff   = ({1'b0, note_range_reg} > 7'(MAX_STEPS)) ? 7'(MAX_STEPS)
                                                                : {1'b0, note_range_reg};
    assign top      = (nr_eff == 7'd0) ? '0 : QW'(nr_eff - 7'd1);
    assign ss_clamp = (scale_size_reg > SCALE_MAX) ? SCALE_MAX : scale_size_reg;
    assign chrom    = (ss_clamp == 5'd0);
    assign ss_eff   = chrom ? CHROMATIC_SIZE : ss_clamp;

    // ---------------- sample and span prep ----------------
    logic signed [SAMPLE_W-1:0] v_reg;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SAMPLE_W:0]   den_full;
    logic [SAMPLE_W+QW-1:0]     num_w;
    logic [SAMPLE_W+QW-1:0]     num_reg;
    logic [SAMPLE_W-1:0]        den_reg;
    logic                       zero_reg;
    logic                       topc_reg;
    logic [QW-1:0]              top_reg;

    assign diff     = {v_reg[SAMPLE_W-1], v_reg} - {span_low_reg[SAMPLE_W-1], span_low_reg};
    assign den_full = {span_high_reg[SAMPLE_W-1], span_high_reg}
                    - {span_low_reg[SAMPLE_W-1], span_low_reg};
    assign num_w    = (SAMPLE_W+QW)'(diff[SAMPLE_W-1:0]) * (SAMPLE_W+QW)'(top);

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            v_reg <= in_pitch;
        end
        if (cmd.prep) begin
            num_reg  <= num_w;
            den_reg  <= den_full[SAMPLE_W-1:0];
            // at or below span low or empty span -> step 0; at or above span high -> clamp
            zero_reg <= (span_high_reg <= span_low_reg) || (v_reg <= span_low_reg);
            topc_reg <= (v_reg >= span_high_reg);
            top_reg  <= top;
        end
    end

    // ---------------- shared divider ----------------
    logic [NW-1:0]  div_n;
    logic [DVW-1:0] div_d;
    logic           div_done;
    logic [QW-1:0]  div_q;
    logic [NW-1:0]  div_r;

    logic [QW-1:0]     s_reg;
    logic [TBL_AW-1:0] degree_reg;
    logic [QW-1:0]     octave_reg;
    logic              chrom_reg;

    // pass 0: (2*num + den) / (2*den), round half up
    // pass 1: step / scale size -> octave, remainder -> degree
    assign div_n = cmd.div_sel ? NW'(s_reg)
                               : (NW'({num_reg, 1'b0}) + NW'(den_reg));
    assign div_d = cmd.div_sel ? DVW'(ss_eff) : DVW'({den_reg, 1'b0});

    cvq_div #(
        .NW  (NW),
        .DVW (DVW),
        .QW  (QW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign sts.div_done = div_done;

    always_ff @(posedge aclk) begin
        if (cmd.s_latch) begin
            s_reg <= zero_reg ? '0 : (topc_reg ? top_reg : div_q);
        end
        if (cmd.dm_latch) begin
            degree_reg <= div_r[TBL_AW-1:0];
            octave_reg <= div_q;
            chrom_reg  <= chrom;
        end
    end

    // ---------------- scale table ----------------
    logic [SAMPLE_W-1:0] tbl_rdata;

    cvq_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .aclk  (aclk),
        .we    (cmd.tbl_wr),
        .waddr (in_idx),
        .wdata (in_val),
        .raddr (degree_reg),
        .rdata (tbl_rdata)
    );

    // ---------------- pitch ----------------
    logic [PITCH_W-1:0] base;
    logic [PITCH_W-1:0] oct_volts;
    logic [PITCH_W-1:0] pitch_reg;

    assign base = chrom_reg ? (PITCH_W'(degree_reg) * PITCH_W'(SEMITONE))
                            : {{(PITCH_W-SAMPLE_W){tbl_rdata[SAMPLE_W-1]}}, tbl_rdata};
    assign oct_volts = PITCH_W'(octave_reg) * PITCH_W'(ONE_VOLT);

    always_ff @(posedge aclk) begin
        if (cmd.pitch_calc) begin
            pitch_reg <= base + oct_volts;
        end
    end

    // ---------------- voice state ----------------
    logic [PITCH_W-1:0] held_pitch_reg;
    logic               held_valid_reg;
    logic [CHAN_W-1:0]  chan_reg;
    logic [CHAN_W-1:0]  chan_next;

    assign chan_next    = (chan_reg == CHAN_W'(VOICES - 1)) ? '0 : chan_reg + 1'b1;
    assign sts.new_note = !held_valid_reg || (held_pitch_reg != pitch_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_pitch_reg <= '0;
            held_valid_reg <= 1'b0;
            chan_reg       <= '0;
        end else if (cmd.emit_en) begin
            if (cmd.emit_kind == EMIT_CLOSE) begin
                chan_reg <= chan_next;
            end
            if (cmd.emit_kind == EMIT_PLAY) begin
                held_pitch_reg <= pitch_reg;
                held_valid_reg <= 1'b1;
            end
        end
    end

    // ---------------- output register ----------------
    logic               out_valid_reg;
    logic [CHAN_W-1:0]  out_chan_reg;
    logic               out_gate_reg;
    logic               out_pw_reg;
    logic [PITCH_W-1:0] out_pitch_reg;
    logic [STEP_W-1:0]  out_step_reg;
    logic               out_last_reg;

    assign sts.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_en) begin
            out_chan_reg <= chan_reg;
            case (cmd.emit_kind)
                EMIT_PLAY: begin
                    out_gate_reg  <= 1'b1;
                    out_pw_reg    <= 1'b1;
                    out_pitch_reg <= pitch_reg;
                    out_step_reg  <= STEP_W'(s_reg);
                    out_last_reg  <= 1'b1;
                end
                EMIT_CLOSE: begin
                    out_gate_reg  <= 1'b0;
                    out_pw_reg    <= 1'b0;
                    out_pitch_reg <= '0;
                    out_step_reg  <= '0;
                    out_last_reg  <= 1'b0;
                end
                default: begin
                    out_gate_reg  <= 1'b0;
                    out_pw_reg    <= 1'b0;
                    out_pitch_reg <= '0;
                    out_step_reg  <= '0;
                    out_last_reg  <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_step_reg, out_pitch_reg, out_pw_reg, out_gate_reg,
                       out_chan_reg};

endmodule

`default_nettype wire

// ===== rtl/cvq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cvq_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          s_tuser,
    output logic               s_tready,
    input  wire cvq_pkg::sts_t sts,
    output cvq_pkg::cmd_t      cmd
);

    import cvq_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_OFF   = 4'd1;
    localparam logic [3:0] ST_PREP  = 4'd2;
    localparam logic [3:0] ST_DIV1S = 4'd3;
    localparam logic [3:0] ST_DIV1W = 4'd4;
    localparam logic [3:0] ST_DIV2S = 4'd5;
    localparam logic [3:0] ST_DIV2W = 4'd6;
    localparam logic [3:0] ST_READ  = 4'd7;
    localparam logic [3:0] ST_PITCH = 4'd8;
    localparam logic [3:0] ST_CHECK = 4'd9;
    localparam logic [3:0] ST_PLAY  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.cap    = 1'b1;
                    cmd.tbl_wr = s_tuser;
                    if (!s_tuser) begin
                        state_next = sts.playing ? ST_PREP : ST_OFF;
                    end
                end
            end
            ST_OFF: begin
                if (sts.out_free) begin
                    cmd.emit_en   = 1'b1;
                    cmd.emit_kind = EMIT_OFF;
                    state_next    = ST_IDLE;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV1S;
            end
            ST_DIV1S: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b0;
                state_next    = ST_DIV1W;
            end
            ST_DIV1W: begin
                if (sts.div_done) begin
                    cmd.s_latch = 1'b1;
                    state_next  = ST_DIV2S;
                end
            end
            ST_DIV2S: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_DIV2W;
            end
            ST_DIV2W: begin
                cmd.div_sel = 1'b1;
                if (sts.div_done) begin
                    cmd.dm_latch = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_PITCH;
            end
            ST_PITCH: begin
                cmd.pitch_calc = 1'b1;
                state_next     = ST_CHECK;
            end
            ST_CHECK: begin
                if (!sts.new_note) begin
                    state_next = ST_PLAY;
                end else if (sts.out_free) begin
                    cmd.emit_en   = 1'b1;
                    cmd.emit_kind = EMIT_CLOSE;
                    state_next    = ST_PLAY;
                end
            end
            ST_PLAY: begin
                if (sts.out_free) begin
                    cmd.emit_en   = 1'b1;
                    cmd.emit_kind = EMIT_PLAY;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cv_scale_quantizer_voice_rotator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// CV scale quantizer with rotating voice channels.
// Channels: cfg_* writes one config register per beat (index 0..4, always ready).
//   s_* takes one item per beat; s_tuser = 1 writes a scale table entry, 0 is a
//   pitch sample. m_* returns result beats; m_tlast marks the final beat of an item.
// A pitch sample is quantized to a step (span scaling, round half up), split into
// degree and octave by the scale size, and turned into a V/oct pitch. A new pitch
// first gives a gate-close beat on the current channel, then a play beat on the
// next channel; a repeated pitch gives only the play beat.
// Flow: a table write leaves the controller idle and ready for the next item. A sample
// with the gate low passes through the off state. A playing sample runs through prep,
// two passes through one shared radix-2 divider, one quotient bit per cycle, then the
// read, pitch, check and play states. A new pitch loads its close beat in the check state
// and its play beat in the play state; a repeated pitch shows only the play beat.
// One item is in work at a time; s_tready is high while the controller is idle.
// A beat waits in the output register while m_tready is low; the controller stalls
// at its next beat and s_tready returns once the item's last beat is loaded.
// Reset (aresetn low, synchronous) restores default config, clears the held note
// and the channel pointer, and empties the output register. Scale table undefined.
module cv_scale_quantizer_voice_rotator #(
    parameter int VOICES    = 16,
    parameter int MAX_STEPS = 48
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // config write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cvq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cvq_pkg::SAMPLE_W-1:0]   cfg_data,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // pitch_in[14:0], gate_level[29:15], entry_index[33:30], entry_value[48:34]
    input  wire logic [cvq_pkg::S_TDATA_W-1:0]  s_tdata,
    // action[0]
    input  wire logic                           s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // channel[3:0], gate_on[4], pitch_write[5], pitch_out[23:6], step_index[29:24]
    output logic      [cvq_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                                m_tlast
);

    import cvq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // the user changes config only while idle; the block does not enforce it, cfg_ready is tied high
    assign cfg_ready = 1'b1;

    cvq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cvq_dp #(
        .VOICES    (VOICES),
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import cvq_pkg::*;

    localparam int VOICES        = 16;
    localparam int MAX_STEPS     = 48;
    localparam int RAND_ITEMS    = 1800;
    localparam int PHASES        = 14;
    localparam int SETTLE_CYCLES = 40;    // longer than one playing sample, plus slack
    localparam int HOLD_CYCLES   = 500;   // long receiver back-pressure stretch
    localparam int TIMEOUT_NS    = 2_000_000;

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_index_t            cfg_index;
    logic [SAMPLE_W-1:0]   cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    cv_scale_quantizer_voice_rotator #(
        .VOICES    (VOICES),
        .MAX_STEPS (MAX_STEPS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------
    // One result beat as the block should send it.
    typedef struct packed {
        logic [CHAN_W-1:0]         channel;
        logic                      gate_on;
        logic                      pitch_write;
        logic signed [PITCH_W-1:0] pitch_out;
        logic [STEP_W-1:0]         step_index;
        logic                      last;
    } voice_beat_t;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_ENTRY, ROW_CFG} row_kind_t;

    // Directed stimulus row. typed = 1 pins pitch_out / step_index of the
    // final beat to the hand-computed values.
    typedef struct packed {
        row_kind_t                  kind;
        logic signed [SAMPLE_W-1:0] pitch;
        logic signed [SAMPLE_W-1:0] gate;
        logic [TBL_AW-1:0]          idx;
        logic signed [SAMPLE_W-1:0] val;
        cfg_index_t                 reg_sel;
        bit                         typed;
        int                         exp_pitch;
        int                         exp_step;
    } stim_row_t;

    // ------------------------------------------------------------------
    // Quantizer shadow state and settings
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] note_tbl [TBL_DEPTH];
    logic signed [PITCH_W-1:0]  held_pitch   = '0;
    bit                         held_valid   = 1'b0;
    logic [CHAN_W-1:0]          voice_ptr    = '0;
    logic signed [SAMPLE_W-1:0] span_lo_q    = 15'sd0;
    logic signed [SAMPLE_W-1:0] span_hi_q    = 15'sd12000;
    logic [5:0]                 range_q      = 6'd16;
    logic [4:0]                 size_q       = 5'd0;
    logic                       gate_used_q  = 1'b0;

    voice_beat_t expected_beats[$];
    voice_beat_t head_beat;
    voice_beat_t tail_beat;
    stim_row_t   rows[$];

    bit no_idle           = 1'b0;  // both sides stream back to back
    bit long_hold_pending = 1'b0;  // receiver picks this up on its next beat

    int n_errors  = 0;
    int n_samples = 0;
    int n_entries = 0;
    int n_cfg     = 0;
    int n_beats   = 0;
    int n_closes  = 0;
    int n_offs    = 0;
    int n_holds   = 0;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, %0d beats still expected", $time, expected_beats.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void apply_reg(cfg_index_t sel, logic [SAMPLE_W-1:0] d);
        case (sel)
            CFG_SPAN_LOW:   span_lo_q   = d;
            CFG_SPAN_HIGH:  span_hi_q   = d;
            CFG_NOTE_RANGE: range_q     = d[5:0];
            CFG_SCALE_SIZE: size_q      = d[4:0];
            CFG_GATE_USED:  gate_used_q = d[0];
            default: ;
        endcase
    endfunction

    function automatic void push_beat(logic [CHAN_W-1:0] ch, logic g, logic pw,
                                      longint p, int stp, logic lst);
        voice_beat_t b;
        b.channel     = ch;
        b.gate_on     = g;
        b.pitch_write = pw;
        b.pitch_out   = p[PITCH_W-1:0];
        b.step_index  = stp[STEP_W-1:0];
        b.last        = lst;
        expected_beats.push_back(b);
    endfunction

    // Works out the beats one accepted input item causes and updates the
    // held note and channel pointer.
    function automatic void quantize_item(bit action,
                                          logic signed [SAMPLE_W-1:0] pin,
                                          logic signed [SAMPLE_W-1:0] glev,
                                          logic [TBL_AW-1:0] idx,
                                          logic signed [SAMPLE_W-1:0] val);
        longint v, lo, hi, top, num, den, stp, pv;
        int     nr, ss, degree, octave;
        if (action) begin
            note_tbl[idx] = val;
            return;
        end
        // gate low: single gate-off beat on the current channel, held note kept
        if (gate_used_q && glev < GATE_ON_LEVEL) begin
            push_beat(voice_ptr, 1'b0, 1'b0, 0, 0, 1'b1);
            return;
        end
        v  = pin;
        lo = span_lo_q;
        hi = span_hi_q;
        nr = range_q;
        if (nr > MAX_STEPS)
            nr = MAX_STEPS;
        top = (nr >= 1) ? nr - 1 : 0;
        // empty span or input at/below the bottom gives step 0
        if (hi <= lo || v <= lo) begin
            stp = 0;
        end else begin
            num = (v - lo) * top;
            den = hi - lo;
            stp = (2 * num + den) / (2 * den);   // round half up
            if (stp > top)
                stp = top;
        end
        ss = size_q;
        if (ss > SCALE_MAX)
            ss = SCALE_MAX;
        if (ss == 0) begin
            degree = int'(stp) % CHROMATIC_SIZE;
            octave = int'(stp) / CHROMATIC_SIZE;
            pv     = degree * SEMITONE;
        end else begin
            degree = int'(stp) % ss;
            octave = int'(stp) / ss;
            pv     = note_tbl[degree];
        end
        pv = pv + octave * ONE_VOLT;
        // new pitch: close the old channel, then advance
        if (!held_valid || held_pitch != pv) begin
            push_beat(voice_ptr, 1'b0, 1'b0, 0, 0, 1'b0);
            voice_ptr = CHAN_W'((voice_ptr + 1) % VOICES);
        end
        held_pitch = pv[PITCH_W-1:0];
        held_valid = 1'b1;
        push_beat(voice_ptr, 1'b1, 1'b1, pv, int'(stp), 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void cmp_field(string name, longint want, longint got);
        if (want != got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (expected_beats.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected beat, expected none, actual tdata %h tlast %b",
                         $time, m_tdata, m_tlast);
            end else begin
                head_beat = expected_beats.pop_front();
                n_beats++;
                if (!head_beat.gate_on)
                    if (head_beat.last) n_offs++; else n_closes++;
                cmp_field("channel",     head_beat.channel,     m_tdata[3:0]);
                cmp_field("gate_on",     head_beat.gate_on,     m_tdata[4]);
                cmp_field("pitch_write", head_beat.pitch_write, m_tdata[5]);
                cmp_field("pitch_out",   head_beat.pitch_out,   $signed(m_tdata[23:6]));
                cmp_field("step_index",  head_beat.step_index,  m_tdata[29:24]);
                cmp_field("tdata pad",   0,                     m_tdata[31:30]);
                cmp_field("tlast",       head_beat.last,        m_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stall per beat, one long hold on request.
    // The hold is counted here while the sender keeps offering items, so the
    // block fills its output register and drops s_tready.
    // ------------------------------------------------------------------
    initial begin : sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (long_hold_pending) begin
                stall = HOLD_CYCLES;
                long_hold_pending = 1'b0;
                n_holds++;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 10);
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offers one item after a random gap; returns at the accepting edge.
    // With no gap s_tvalid stays high, so it gets only one update per step.
    task automatic drive_item(bit action, logic signed [SAMPLE_W-1:0] pitch,
                              logic signed [SAMPLE_W-1:0] gate,
                              logic [TBL_AW-1:0] idx, logic signed [SAMPLE_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {7'd0, val, idx, gate, pitch};
        do @(posedge aclk); while (s_tready !== 1'b1);
        quantize_item(action, pitch, gate, idx, val);
        if (action) n_entries++; else n_samples++;
    endtask

    task automatic write_reg(cfg_index_t sel, logic [SAMPLE_W-1:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= d;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        apply_reg(sel, d);
        n_cfg++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, let every expected beat drain, then cover a table write
    // or gate-off item that may still be in flight.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_level();
        logic [SAMPLE_W-1:0] raw;
        raw = SAMPLE_W'($urandom);
        if ($urandom_range(0, 1))
            return raw;                                   // any 15-bit pattern
        return SAMPLE_W'($urandom_range(0, 24000) - 12000);
    endfunction

    // New settings for one random phase; phases 0 and 1 take the extremes.
    task automatic choose_settings(int ph);
        int a, b, t, nr, ss;
        a = $urandom_range(0, 24000) - 12000;
        b = $urandom_range(0, 24000) - 12000;
        if (a > b) begin
            t = a; a = b; b = t;
        end
        if ($urandom_range(0, 5) == 0)
            b = a - $urandom_range(0, 100);               // empty span
        case ($urandom_range(0, 9))
            0: case ($urandom_range(0, 3))
                   0: nr = 0;
                   1: nr = 1;
                   2: nr = 49;
                   default: nr = 63;
               endcase
            1: nr = MAX_STEPS;
            2: nr = 2;
            default: nr = $urandom_range(2, 47);
        endcase
        case ($urandom_range(0, 5))
            0: ss = 0;
            1: ss = $urandom_range(17, 31);
            2: ss = 16;
            default: ss = $urandom_range(1, 15);
        endcase
        if (ph == 0) begin
            a = -12000; b = 12000; nr = MAX_STEPS; ss = 1;
        end else if (ph == 1) begin
            a = 12000; b = -12000; nr = 2; ss = 16;
        end
        settle();
        write_reg(CFG_SPAN_LOW,   SAMPLE_W'(a));
        write_reg(CFG_SPAN_HIGH,  SAMPLE_W'(b));
        write_reg(CFG_NOTE_RANGE, SAMPLE_W'(nr));
        write_reg(CFG_SCALE_SIZE, SAMPLE_W'(ss));
        write_reg(CFG_GATE_USED,  SAMPLE_W'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    function automatic void add_sample(int p, int g, bit typed, int ep, int es);
        stim_row_t r;
        r = '0;
        r.kind      = ROW_SAMPLE;
        r.pitch     = SAMPLE_W'(p);
        r.gate      = SAMPLE_W'(g);
        r.typed     = typed;
        r.exp_pitch = ep;
        r.exp_step  = es;
        rows.push_back(r);
    endfunction

    function automatic void add_entry(int idx, int val);
        stim_row_t r;
        r = '0;
        r.kind = ROW_ENTRY;
        r.idx  = TBL_AW'(idx);
        r.val  = SAMPLE_W'(val);
        rows.push_back(r);
    endfunction

    function automatic void add_cfg(cfg_index_t sel, int val);
        stim_row_t r;
        r = '0;
        r.kind    = ROW_CFG;
        r.reg_sel = sel;
        r.val     = SAMPLE_W'(val);
        rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int ph, k, r, p, g, lo, hi, last_p;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SPAN_LOW;
        cfg_data  = '0;
        aresetn   = 1'b0;

        // Reset settings: span 0..12000, 16 steps (800 per step), chromatic,
        // gate ignored. Full span maps to step 15 = degree 3, octave 1.
        add_sample(0,      -16384, 1, 0,    0);   // first note: close + play
        add_sample(0,       16383, 1, 0,    0);   // same pitch: play only
        add_sample(12000,   0,     1, 1500, 15);  // top of span
        add_sample(-12000,  0,     1, 0,    0);   // below span
        add_sample(16383,   0,     1, 1500, 15);  // above span, clamped
        add_sample(-16384,  0,     1, 0,    0);
        add_sample(400,     0,     1, 100,  1);   // exactly half a step: rounds up
        add_sample(399,     0,     1, 0,    0);   // just under half a step
        add_entry(0,   12000);
        add_entry(15, -12000);
        add_entry(5,  -16384);
        add_entry(10,  16383);
        add_cfg(CFG_GATE_USED, 1);
        add_sample(12000,   1199,   1, 0,    0);  // gate just below 1 V: off
        add_sample(12000,   1200,   1, 1500, 15); // gate exactly 1 V: playing
        add_sample(12000,  -16384,  1, 0,    0);  // gate off
        add_sample(6000,    16383,  1, 800,  8);
        add_cfg(CFG_NOTE_RANGE, 63);              // saturates at MAX_STEPS
        add_sample(12000,   16383,  1, 4700, 47);
        add_cfg(CFG_NOTE_RANGE, 0);               // only step 0
        add_sample(12000,   16383,  1, 0,    0);
        add_cfg(CFG_NOTE_RANGE, 1);
        add_sample(12000,   16383,  1, 0,    0);
        add_cfg(CFG_NOTE_RANGE, MAX_STEPS);
        add_cfg(CFG_SCALE_SIZE, 31);              // saturates at 16 entries
        add_sample(12000,   16383,  0, 0,    0);
        add_cfg(CFG_SPAN_LOW, 12000);             // empty span: step 0
        add_sample(12000,   16383,  1, 12000, 0);
        add_cfg(CFG_SCALE_SIZE, 1);
        add_cfg(CFG_SPAN_LOW, -12000);
        add_sample(12000,   16383,  1, 68400, 47); // highest pitch: 47 octaves up
        add_sample(-12000,  16383,  1, 12000, 0);
        add_cfg(CFG_SPAN_HIGH, -12000);
        add_sample(0,       16383,  1, 12000, 0);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Load the whole scale table so no unwritten entry is ever read.
        for (k = 0; k < TBL_DEPTH; k++)
            drive_item(1'b1, rand_level(), rand_level(), TBL_AW'(k), rand_level());

        for (k = 0; k < rows.size(); k++) begin
            case (rows[k].kind)
                ROW_CFG: begin
                    settle();
                    write_reg(rows[k].reg_sel, rows[k].val);
                end
                ROW_ENTRY: drive_item(1'b1, '0, '0, rows[k].idx, rows[k].val);
                default: begin
                    drive_item(1'b0, rows[k].pitch, rows[k].gate, '0, '0);
                    if (rows[k].typed) begin
                        tail_beat = expected_beats.pop_back();
                        tail_beat.pitch_out  = PITCH_W'(rows[k].exp_pitch);
                        tail_beat.step_index = STEP_W'(rows[k].exp_step);
                        expected_beats.push_back(tail_beat);
                    end
                end
            endcase
        end

        // Random phases: new settings each, mostly in-span samples with many
        // repeated pitches, some table rewrites and raw out-of-range values.
        last_p = 0;
        for (ph = 0; ph < PHASES; ph++) begin
            choose_settings(ph);
            no_idle = (ph % 4 == 3);
            if (ph == 2)
                long_hold_pending = 1'b1;
            lo = span_lo_q;
            hi = span_hi_q;
            for (k = 0; k < RAND_ITEMS / PHASES; k++) begin
                r = $urandom_range(0, 99);
                if ($urandom_range(0, 3) != 0)
                    g = $urandom_range(1200, 16383);
                else
                    g = $urandom_range(0, 17583) - 16384;
                if (r < 10) begin
                    drive_item(1'b1, rand_level(), rand_level(),
                               TBL_AW'($urandom_range(0, 15)), rand_level());
                end else begin
                    if (r < 35)
                        p = last_p;
                    else if (r < 90 && hi > lo)
                        p = lo + $urandom_range(0, hi - lo);
                    else
                        p = $urandom_range(0, 32767) - 16384;
                    last_p = p;
                    drive_item(1'b0, SAMPLE_W'(p), SAMPLE_W'(g),
                               TBL_AW'($urandom), SAMPLE_W'($urandom));
                end
            end
        end
        no_idle = 1'b0;

        settle();
        $display("Covered %0d samples, %0d table writes, %0d register writes, %0d long holds.",
                 n_samples, n_entries, n_cfg, n_holds);
        $display("Checked %0d result beats: %0d channel changes, %0d gate-off beats.",
                 n_beats, n_closes, n_offs);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
